// ===== rtl/lip_pkg.sv =====
// Package: geometry constants, operation codes, set row and result types.
`default_nettype none
package lip_pkg;

  localparam int NUM_SETS    = 64;
  localparam int NUM_WAYS    = 4;
  localparam int BLOCK_BYTES = 64;

  localparam int ADDR_W      = 32;
  localparam int OUT_WAY_W   = 2;
  localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int SET_IW      = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_SHIFT   = OFFSET_BITS + SET_BITS;
  localparam int TAG_BITS    = ADDR_W - TAG_SHIFT;
  localparam int WAY_W       = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_PROBE  = 2'd1,
    OP_FILL   = 2'd2,
    OP_INVAL  = 2'd3
  } op_t;

  typedef logic [SET_IW-1:0]   set_idx_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [WAY_W-1:0]    way_t;

  // One set: recency order (MRU first), valid bits and tags per physical way.
  typedef struct packed {
    way_t [NUM_WAYS-1:0] order;
    logic [NUM_WAYS-1:0] valid;
    tag_t [NUM_WAYS-1:0] tags;
  } row_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 ev_valid;
    logic [ADDR_W-1:0]    ev_addr;
  } res_t;

  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.order[w] = WAY_W'(w);
      r.valid[w] = 1'b0;
      r.tags[w]  = TAG_BITS'(w);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lip_req_if.sv =====
// Request channel interface: operation and byte address.
`default_nettype none
interface lip_req_if;
  import lip_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] addr;
  modport source (output valid, output op, output addr, input ready);
  modport sink   (input valid, input op, input addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/lip_rsp_if.sv =====
// Response channel interface: lookup result and eviction info.
`default_nettype none
interface lip_rsp_if;
  import lip_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way;
  logic                 evicted_valid;
  logic [ADDR_W-1:0]    evicted_block_addr;
  modport source (output valid, output hit, output way, output evicted_valid,
                  output evicted_block_addr, input ready);
  modport sink   (input valid, input hit, input way, input evicted_valid,
                  input evicted_block_addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/lip_ram.sv =====
// Generic one-write one-read RAM with registered read data.
`default_nettype none
module lip_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             re,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lip_update.sv =====
// Way compare, recency update, fill/invalidate and eviction address for one set.
`default_nettype none
module lip_update import lip_pkg::*; (
  input  wire op_t      op,
  input  wire tag_t     tag,
  input  wire set_idx_t set,
  input  wire row_t     row,
  output row_t          row_next,
  output res_t          res
);
  logic [NUM_WAYS-1:0] match;
  logic                found;
  way_t                pos;
  way_t                hway;
  way_t                lru;

  always_comb begin
    match = '0;
    for (int p = 0; p < NUM_WAYS; p++) begin
      match[p] = row.valid[row.order[p]] && (row.tags[row.order[p]] == tag);
    end
    found = 1'b0;
    pos   = '0;
    for (int p = NUM_WAYS - 1; p >= 0; p--) begin
      if (match[p]) begin
        found = 1'b1;
        pos   = WAY_W'(p);
      end
    end
    hway = row.order[pos];
    lru  = row.order[NUM_WAYS-1];

    row_next = row;
    res      = '0;
    res.hit  = found;

    case (op)
      OP_ACCESS: begin
        if (found) begin
          res.way = OUT_WAY_W'(hway);
          for (int i = 1; i < NUM_WAYS; i++) begin
            if (WAY_W'(i) <= pos) begin
              row_next.order[i] = row.order[i-1];
            end
          end
          row_next.order[0] = hway;
        end
      end
      OP_PROBE: begin
        if (found) begin
          res.way = OUT_WAY_W'(hway);
        end
      end
      OP_FILL: begin
        res.way = OUT_WAY_W'(lru);
        if (row.valid[lru]) begin
          res.ev_valid = 1'b1;
          res.ev_addr  = (ADDR_W'(row.tags[lru]) << TAG_SHIFT) |
                         (ADDR_W'(set) << OFFSET_BITS);
        end
        row_next.tags[lru]  = tag;
        row_next.valid[lru] = 1'b1;
      end
      OP_INVAL: begin
        if (found) begin
          res.way = OUT_WAY_W'(hway);
          row_next.valid[hway] = 1'b0;
          for (int i = 0; i < NUM_WAYS - 1; i++) begin
            if (WAY_W'(i) >= pos) begin
              row_next.order[i] = row.order[i+1];
            end
          end
          row_next.order[NUM_WAYS-1] = hway;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/lip_set_assoc_tag_store_core.sv =====
// Top level: set-associative tag store with LIP replacement, two-stage pipe.
//
//  channel | dir | fields                                      | role
//  --------+-----+---------------------------------------------+------------------
//  req     | in  | op[1:0], addr[31:0]                         | lookup/fill/inval
//  rsp     | out | hit, way[1:0], evicted_valid,               | one per request
//          |     | evicted_block_addr[31:0]                    |
//
// One transaction per cycle while rsp is not stalled; a request passes the set row
// RAM read, then compare/update and the result register, before rsp valid.
// Same-set back-to-back requests take the row written the same cycle by forwarding.
// Reset clears the per-set init flags; an uninitialized set reads as empty with
// identity recency order, so no clearing pass is needed.
// A stalled rsp holds the pipe; req.ready drops only while both stages are full.
`default_nettype none
module lip_set_assoc_tag_store_core import lip_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  lip_req_if.sink  req,
  lip_rsp_if.source rsp
);
  localparam int ROW_W = $bits(row_t);

  logic     s1_valid;
  op_t      s1_op;
  logic [ADDR_W-1:0] s1_addr;
  logic     s1_fwd;
  logic     s1_init;
  row_t     fwd_row;
  logic [NUM_SETS-1:0] init;

  logic [ROW_W-1:0] ram_rd;
  row_t     s1_row;
  row_t     upd_row;
  res_t     res;
  set_idx_t in_set;
  set_idx_t s1_set;
  tag_t     s1_tag;

  logic     out_valid;
  res_t     out_res;

  logic     out_adv;
  logic     s1_fire;
  logic     in_fire;

  assign out_adv   = !out_valid || rsp.ready;
  assign s1_fire   = s1_valid && out_adv;
  assign req.ready = !s1_valid || out_adv;
  assign in_fire   = req.valid && req.ready;

  assign in_set = set_idx_t'((req.addr >> OFFSET_BITS) & ADDR_W'(NUM_SETS - 1));
  assign s1_set = set_idx_t'((s1_addr >> OFFSET_BITS) & ADDR_W'(NUM_SETS - 1));
  assign s1_tag = tag_t'(s1_addr >> TAG_SHIFT);

  lip_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk     (clk),
    .we      (s1_fire),
    .wr_addr (s1_set),
    .wr_data (upd_row),
    .re      (in_fire),
    .rd_addr (in_set),
    .rd_data (ram_rd)
  );

  always_comb begin
    if (s1_fwd) begin
      s1_row = fwd_row;
    end else if (s1_init) begin
      s1_row = row_t'(ram_rd);
    end else begin
      s1_row = reset_row();
    end
  end

  lip_update u_update (
    .op       (s1_op),
    .tag      (s1_tag),
    .set      (s1_set),
    .row      (s1_row),
    .row_next (upd_row),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      init      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        init[s1_set] <= 1'b1;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op   <= op_t'(req.op);
      s1_addr <= req.addr;
      s1_init <= init[in_set];
      s1_fwd  <= s1_fire && (s1_set == in_set);
      fwd_row <= upd_row;
    end
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.hit                = out_res.hit;
  assign rsp.way                = out_res.way;
  assign rsp.evicted_valid      = out_res.ev_valid;
  assign rsp.evicted_block_addr = out_res.ev_addr;

  // recency order after update must stay a permutation of the ways
  logic [NUM_WAYS-1:0] perm_mask;
  always_comb begin
    perm_mask = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      perm_mask[upd_row.order[i]] = 1'b1;
    end
  end

  a_perm: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (perm_mask == {NUM_WAYS{1'b1}}))
    else $error("recency order lost a way");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_op == OP_FILL) |-> upd_row.valid[res.way[WAY_W-1:0]])
    else $error("filled way not marked valid");

  a_evict_fill_only: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res.ev_valid) |-> (s1_op == OP_FILL))
    else $error("eviction reported outside fill");

  a_fwd_set: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s1_fire && s1_set == in_set) |=> (s1_valid && s1_fwd))
    else $error("same-set forwarding not captured");

endmodule
`default_nettype wire
